/* hw/rtl/lpmd_pkg.sv */
// Package with the shared types, codes and character classes of the message deframer.
package lpmd_pkg;

  typedef enum logic [2:0] {
    PH_BEFORE_CODE   = 3'd0,
    PH_CODE          = 3'd1,
    PH_BEFORE_LENGTH = 3'd2,
    PH_LENGTH        = 3'd3,
    PH_BEFORE_BODY   = 3'd4,
    PH_BODY          = 3'd5
  } phase_t;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_CODE   = 3'd1;
  localparam logic [2:0] KIND_LENGTH = 3'd2;
  localparam logic [2:0] KIND_BODY   = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic [2:0] ERR_BAD_CODE_START   = 3'd0;
  localparam logic [2:0] ERR_BAD_CODE_CHAR    = 3'd1;
  localparam logic [2:0] ERR_BAD_LENGTH_START = 3'd2;
  localparam logic [2:0] ERR_BAD_DIGIT        = 3'd3;
  localparam logic [2:0] ERR_CODE_LONG        = 3'd4;
  localparam logic [2:0] ERR_LENGTH_LARGE     = 3'd5;

  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

  typedef struct packed {
    logic        incomplete;
    logic [2:0]  error_cause;
    logic        message_done;
    logic [15:0] body_length;
    logic [7:0]  data_byte;
    logic [2:0]  kind;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

/* hw/rtl/length_prefixed_message_deframer_core.sv */
// Top level of the length-prefixed message deframer with its output and skid registers.
//
// The block takes one raw byte per input transaction on the in_ stream channel,
// with in_tlast marking the last byte of a handed-over buffer. For every input
// transaction it gives exactly one output transaction on the out_ channel: out_tuser
// carries the kind (nothing, code character, length, body byte, error), out_tdata
// the byte, the parsed length, the error cause and the incomplete flag, and
// out_tlast is high when the byte completes a message.
// The single configuration register reply_mode is written through cfg_wr_en and
// cfg_wr_data; a write restarts parsing at the new mode's start state.
// One byte is taken every clock while the skid register is empty; the parser state
// is updated in the cycle of acceptance by a single pass of character-class and
// length logic, and the result is registered in the output or skid register.
// When the receiver stalls, the result moves into a one-entry skid register and
// in_tready drops only while that register is full.
// Reset empties both output registers, sets reply_mode to zero and puts the parser
// at the start of a code word.
module length_prefixed_message_deframer_core import lpmd_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter longint unsigned MAX_BODY_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // byte_in[7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // data_byte[7:0], body_length[23:8],
                                  // error_cause[26:24], incomplete[27], zero[31:28]
  output logic [2:0]  out_tuser,  // kind[2:0]
  output logic        out_tlast
);

  localparam int unsigned CNT_W = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned LEN_W = $clog2(MAX_BODY_LEN + 1);

  logic             reply_mode_r;
  phase_t           phase_r;
  phase_t           phase_nxt;
  logic [CNT_W-1:0] code_count_r;
  logic [CNT_W-1:0] code_count_nxt;
  logic [LEN_W-1:0] length_accum_r;
  logic [LEN_W-1:0] length_accum_nxt;
  logic [LEN_W-1:0] body_count_r;
  logic [LEN_W-1:0] body_count_nxt;
  result_t          res;
  result_t          out_r;
  result_t          skid_r;
  logic             out_valid_r;
  logic             skid_valid_r;
  logic             in_acc;
  logic             out_free;

  lpmd_step #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .MAX_BODY_LEN(MAX_BODY_LEN),
    .CNT_W(CNT_W),
    .LEN_W(LEN_W)
  ) u_step (
    .reply_mode      (reply_mode_r),
    .phase           (phase_r),
    .code_count      (code_count_r),
    .length_accum    (length_accum_r),
    .body_count      (body_count_r),
    .byte_in         (in_tdata),
    .chunk_last      (in_tlast),
    .phase_nxt       (phase_nxt),
    .code_count_nxt  (code_count_nxt),
    .length_accum_nxt(length_accum_nxt),
    .body_count_nxt  (body_count_nxt),
    .res             (res)
  );

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_mode_r   <= 1'b0;
      phase_r        <= PH_BEFORE_CODE;
      code_count_r   <= '0;
      length_accum_r <= '0;
      body_count_r   <= '0;
    end else if (cfg_wr_en) begin
      reply_mode_r   <= cfg_wr_data;
      phase_r        <= cfg_wr_data ? PH_BEFORE_LENGTH : PH_BEFORE_CODE;
      code_count_r   <= '0;
      length_accum_r <= '0;
      body_count_r   <= '0;
    end else if (in_acc) begin
      phase_r        <= phase_nxt;
      code_count_r   <= code_count_nxt;
      length_accum_r <= length_accum_nxt;
      body_count_r   <= body_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
          out_r       <= res;
        end else begin
          skid_valid_r <= 1'b1;
          skid_r       <= res;
        end
      end else if (out_tready) begin
        out_valid_r  <= skid_valid_r;
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.message_done;
  assign out_tdata  = {4'b0000, out_r.incomplete, out_r.error_cause,
                       out_r.body_length, out_r.data_byte};

endmodule

/* hw/rtl/lpmd_step.sv */
// Per-byte parser logic: next phase, counters and the result for one input byte.
module lpmd_step import lpmd_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter longint unsigned MAX_BODY_LEN = 65535,
  parameter int unsigned CNT_W = 6,
  parameter int unsigned LEN_W = 16
) (
  input  logic             reply_mode,
  input  phase_t           phase,
  input  logic [CNT_W-1:0] code_count,
  input  logic [LEN_W-1:0] length_accum,
  input  logic [LEN_W-1:0] body_count,
  input  logic [7:0]       byte_in,
  input  logic             chunk_last,
  output phase_t           phase_nxt,
  output logic [CNT_W-1:0] code_count_nxt,
  output logic [LEN_W-1:0] length_accum_nxt,
  output logic [LEN_W-1:0] body_count_nxt,
  output result_t          res
);

  localparam int unsigned EXT_W = LEN_W + 4;

  logic             c_ws;
  logic             c_alpha;
  logic             c_digit;
  logic [EXT_W-1:0] acc_ext;
  logic [EXT_W-1:0] len_next;
  logic             len_over;
  logic [LEN_W:0]   body_inc;
  logic             code_full;
  logic             body_end;
  phase_t           start_phase;

  assign c_ws        = is_ws(byte_in);
  assign c_alpha     = is_alpha(byte_in);
  assign c_digit     = is_digit(byte_in);
  assign acc_ext     = EXT_W'(length_accum);
  assign len_next    = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(byte_in[3:0]);
  assign len_over    = len_next > EXT_W'(MAX_BODY_LEN);
  assign body_inc    = (LEN_W+1)'(body_count) + (LEN_W+1)'(1);
  assign body_end    = body_inc >= (LEN_W+1)'(length_accum);
  assign code_full   = code_count >= CNT_W'(MAX_CODE_LEN);
  assign start_phase = reply_mode ? PH_BEFORE_LENGTH : PH_BEFORE_CODE;

  always_comb begin
    res = '0;
    unique case (phase)
      PH_BEFORE_CODE: begin
        if (c_alpha) begin
          res.kind      = KIND_CODE;
          res.data_byte = byte_in;
        end else if (!c_ws) begin
          res.kind        = KIND_ERROR;
          res.error_cause = ERR_BAD_CODE_START;
        end
      end
      PH_CODE: begin
        if (c_alpha || c_digit || byte_in == CHAR_UNDERSCORE) begin
          if (code_full) begin
            res.kind        = KIND_ERROR;
            res.error_cause = ERR_CODE_LONG;
          end else begin
            res.kind      = KIND_CODE;
            res.data_byte = byte_in;
          end
        end else if (!c_ws) begin
          res.kind        = KIND_ERROR;
          res.error_cause = ERR_BAD_CODE_CHAR;
        end
      end
      PH_BEFORE_LENGTH, PH_LENGTH: begin
        if (c_digit) begin
          if (len_over) begin
            res.kind        = KIND_ERROR;
            res.error_cause = ERR_LENGTH_LARGE;
          end
        end else if (c_ws) begin
          if (phase == PH_LENGTH) begin
            res.kind         = KIND_LENGTH;
            res.body_length  = 16'(length_accum);
            res.message_done = (length_accum == '0);
          end
        end else begin
          res.kind        = KIND_ERROR;
          res.error_cause = (phase == PH_BEFORE_LENGTH) ? ERR_BAD_LENGTH_START
                                                        : ERR_BAD_DIGIT;
        end
      end
      PH_BEFORE_BODY, PH_BODY: begin
        if (!(phase == PH_BEFORE_BODY && c_ws)) begin
          res.kind         = KIND_BODY;
          res.data_byte    = byte_in;
          res.message_done = body_end;
        end
      end
      default: res = '0;
    endcase
    res.incomplete = chunk_last && !res.message_done && (res.kind != KIND_ERROR);
  end

  always_comb begin
    phase_nxt        = phase;
    code_count_nxt   = code_count;
    length_accum_nxt = length_accum;
    body_count_nxt   = body_count;
    unique case (phase)
      PH_BEFORE_CODE: begin
        if (c_alpha) begin
          phase_nxt      = PH_CODE;
          code_count_nxt = CNT_W'(1);
        end
      end
      PH_CODE: begin
        if (c_alpha || c_digit || byte_in == CHAR_UNDERSCORE) begin
          code_count_nxt = code_count + CNT_W'(1);
        end else if (c_ws) begin
          phase_nxt = PH_BEFORE_LENGTH;
        end
      end
      PH_BEFORE_LENGTH, PH_LENGTH: begin
        if (c_digit) begin
          length_accum_nxt = len_next[LEN_W-1:0];
          phase_nxt        = PH_LENGTH;
        end else if (c_ws && phase == PH_LENGTH) begin
          body_count_nxt = '0;
          phase_nxt      = PH_BEFORE_BODY;
        end
      end
      PH_BEFORE_BODY, PH_BODY: begin
        if (!(phase == PH_BEFORE_BODY && c_ws)) begin
          phase_nxt      = PH_BODY;
          body_count_nxt = body_inc[LEN_W-1:0];
        end
      end
      default: phase_nxt = start_phase;
    endcase
    if (res.kind == KIND_ERROR || res.message_done ||
        !(phase == PH_BEFORE_CODE || phase == PH_CODE || phase == PH_BEFORE_LENGTH ||
          phase == PH_LENGTH || phase == PH_BEFORE_BODY || phase == PH_BODY)) begin
      phase_nxt        = start_phase;
      code_count_nxt   = '0;
      length_accum_nxt = '0;
      body_count_nxt   = '0;
    end
  end

endmodule

/* test/tb_length_prefixed_message_deframer_core.sv */
// Self-checking testbench for the length-prefixed message deframer core.
module tb_length_prefixed_message_deframer_core;
  import lpmd_pkg::*;

  localparam int MAX_CODE = 32;
  localparam int MAX_BODY = 65535;
  localparam int ITEM_TARGET = 1650;
  localparam int CYCLE_LIMIT = 600000;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC,
    RX_BURSTY
  } rx_mode_t;

  typedef struct packed {
    logic       is_cfg;
    logic [7:0] b;
    logic       last;
    logic [5:0] reps;
    logic       pinned;
    result_t    want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  logic    cur_mode;
  phase_t  parse_phase;
  int      code_chars;
  int      msg_length;
  int      body_bytes;
  result_t pending_parse_results [$];
  result_t oldest;
  dir_row_t dir_rows [$];

  int items_sent = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int next_cfg_at;
  int pick;

  rx_mode_t   rx_mode = RX_ALWAYS;
  int         rx_seg_left = 0;
  int         rx_hold = 0;
  logic [1:0] rx_tick = 2'd0;

  length_prefixed_message_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic void restart_parser();
    parse_phase = cur_mode ? PH_BEFORE_LENGTH : PH_BEFORE_CODE;
    code_chars = 0;
    msg_length = 0;
    body_bytes = 0;
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] c, input logic last);
    result_t res;
    int nxt;
    res = '0;
    case (parse_phase)
      PH_BEFORE_CODE: begin
        if (is_letter(c)) begin
          res.kind = KIND_CODE;
          res.data_byte = c;
          code_chars = 1;
          parse_phase = PH_CODE;
        end else if (!is_space(c)) begin
          res.kind = KIND_ERROR;
          res.error_cause = ERR_BAD_CODE_START;
        end
      end
      PH_CODE: begin
        if (is_letter(c) || is_num(c) || c == CHAR_UNDERSCORE) begin
          if (code_chars >= MAX_CODE) begin
            res.kind = KIND_ERROR;
            res.error_cause = ERR_CODE_LONG;
          end else begin
            res.kind = KIND_CODE;
            res.data_byte = c;
            code_chars++;
          end
        end else if (is_space(c)) begin
          parse_phase = PH_BEFORE_LENGTH;
        end else begin
          res.kind = KIND_ERROR;
          res.error_cause = ERR_BAD_CODE_CHAR;
        end
      end
      PH_BEFORE_LENGTH, PH_LENGTH: begin
        if (is_num(c)) begin
          nxt = msg_length * 10 + int'(c) - 48;
          if (nxt > MAX_BODY) begin
            res.kind = KIND_ERROR;
            res.error_cause = ERR_LENGTH_LARGE;
          end else begin
            msg_length = nxt;
            parse_phase = PH_LENGTH;
          end
        end else if (is_space(c)) begin
          if (parse_phase == PH_LENGTH) begin
            res.kind = KIND_LENGTH;
            res.body_length = msg_length[15:0];
            if (msg_length == 0) begin
              res.message_done = 1'b1;
            end else begin
              body_bytes = 0;
              parse_phase = PH_BEFORE_BODY;
            end
          end
        end else begin
          res.kind = KIND_ERROR;
          res.error_cause = (parse_phase == PH_BEFORE_LENGTH) ? ERR_BAD_LENGTH_START
                                                              : ERR_BAD_DIGIT;
        end
      end
      PH_BEFORE_BODY, PH_BODY: begin
        if (!(parse_phase == PH_BEFORE_BODY && is_space(c))) begin
          parse_phase = PH_BODY;
          res.kind = KIND_BODY;
          res.data_byte = c;
          body_bytes++;
          if (body_bytes >= msg_length) res.message_done = 1'b1;
        end
      end
      default: restart_parser();
    endcase
    if (res.kind == KIND_ERROR || res.message_done) restart_parser();
    res.incomplete = last && !res.message_done && res.kind != KIND_ERROR;
    return res;
  endfunction

  function automatic dir_row_t plain_row(input logic [7:0] b, input int reps, input logic last);
    dir_row_t r;
    r = '0;
    r.b = b;
    r.reps = 6'(reps);
    r.last = last;
    return r;
  endfunction

  function automatic dir_row_t pinned_row(input logic [7:0] b, input logic [2:0] kind,
                                          input logic [7:0] data, input logic [15:0] blen,
                                          input logic done);
    dir_row_t r;
    r = plain_row(b, 1, 1'b0);
    r.pinned = 1'b1;
    r.want.kind = kind;
    r.want.data_byte = data;
    r.want.body_length = blen;
    r.want.message_done = done;
    return r;
  endfunction

  function automatic dir_row_t error_row(input logic [7:0] b, input logic [2:0] cause);
    dir_row_t r;
    r = pinned_row(b, KIND_ERROR, 8'h00, 16'd0, 1'b0);
    r.want.error_cause = cause;
    return r;
  endfunction

  function automatic dir_row_t mode_row(input logic v);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.b = {7'd0, v};
    return r;
  endfunction

  function automatic logic rand_last();
    return $urandom_range(0, 5) == 0;
  endfunction

  function automatic logic [7:0] ws_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'h20 : 8'(8'h09 + k);
  endfunction

  function automatic logic [7:0] letter_char();
    int k;
    k = $urandom_range(0, 51);
    return (k < 26) ? 8'(8'h41 + k) : 8'(8'h61 + k - 26);
  endfunction

  function automatic logic [7:0] code_char();
    int k;
    k = $urandom_range(0, 62);
    if (k < 52) return letter_char();
    if (k < 62) return 8'(8'h30 + k - 52);
    return CHAR_UNDERSCORE;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input logic pinned,
                           input result_t want);
    result_t pred;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pred = deframe_byte(b, last);
    pending_parse_results.push_back(pinned ? want : pred);
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_parse_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = v;
    restart_parser();
  endtask

  task automatic send_message(input logic broken, input int fixed_len, input int body_cap);
    logic [7:0] msg [$];
    logic [7:0] digs [$];
    int n;
    int len;
    int v;
    int k;
    repeat ($urandom_range(0, 2)) msg.push_back(ws_char());
    if (!cur_mode) begin
      n = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
      msg.push_back(letter_char());
      repeat (n - 1) msg.push_back(code_char());
      repeat ($urandom_range(1, 2)) msg.push_back(ws_char());
    end
    if (fixed_len >= 0) begin
      len = fixed_len;
    end else begin
      k = $urandom_range(0, 19);
      if (k == 0) len = $urandom_range(65536, 99999);
      else if (k < 3) len = $urandom_range(13, 200);
      else len = $urandom_range(0, 12);
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) msg.push_back(8'h30);
    v = len;
    do begin
      digs.push_front(8'(8'h30 + v % 10));
      v = v / 10;
    end while (v > 0);
    foreach (digs[i]) msg.push_back(digs[i]);
    if (len <= MAX_BODY) begin
      msg.push_back(ws_char());
      repeat ($urandom_range(0, 2)) msg.push_back(ws_char());
      repeat ((len < body_cap) ? len : body_cap) msg.push_back(8'($urandom_range(0, 255)));
    end
    if (broken && msg.size() > 0) begin
      msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
    end
    foreach (msg[i]) send_byte(msg[i], rand_last(), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rx_seg_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_seg_left <= $urandom_range(20, 200);
    end else begin
      rx_seg_left <= rx_seg_left - 1;
    end
    rx_tick <= rx_tick + 2'd1;
    case (rx_mode)
      RX_ALWAYS: out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(0, 2) != 0);
      RX_PERIODIC: out_tready <= (rx_tick != 2'd3);
      default: begin
        if (rx_hold == 0) begin
          out_tready <= ~out_tready;
          rx_hold <= out_tready ? $urandom_range(1, 20) : $urandom_range(1, 10);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_parse_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected output transaction: kind %0d tdata %h last %b",
                   out_tuser, out_tdata, out_tlast);
        end
        mismatch_count++;
      end else begin
        oldest = pending_parse_results.pop_front();
        if (out_tuser !== oldest.kind || out_tdata[7:0] !== oldest.data_byte ||
            out_tdata[23:8] !== oldest.body_length || out_tlast !== oldest.message_done ||
            out_tdata[26:24] !== oldest.error_cause || out_tdata[27] !== oldest.incomplete ||
            out_tdata[31:28] !== 4'h0) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected kind %0d data %h len %0d done %b cause %0d inc %b",
                     oldest.kind, oldest.data_byte, oldest.body_length, oldest.message_done,
                     oldest.error_cause, oldest.incomplete);
            $display("          actual   kind %0d data %h len %0d done %b cause %0d inc %b pad %h",
                     out_tuser, out_tdata[7:0], out_tdata[23:8], out_tlast, out_tdata[26:24],
                     out_tdata[27], out_tdata[31:28]);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cur_mode = 1'b0;
    restart_parser();
    dir_rows = '{
      pinned_row(8'h20, KIND_NONE, 8'h00, 16'd0, 1'b0),
      pinned_row("A", KIND_CODE, "A", 16'd0, 1'b0),
      plain_row("_", 1, 1'b0),
      plain_row("9", 1, 1'b0),
      plain_row(8'h09, 1, 1'b0),
      plain_row("0", 1, 1'b0),
      pinned_row(8'h0d, KIND_LENGTH, 8'h00, 16'd0, 1'b1),
      error_row("1", ERR_BAD_CODE_START),
      plain_row("z", 1, 1'b0),
      error_row("!", ERR_BAD_CODE_CHAR),
      plain_row("b", 1, 1'b0),
      plain_row(8'h20, 1, 1'b0),
      error_row("x", ERR_BAD_LENGTH_START),
      plain_row("c", 1, 1'b0),
      plain_row(8'h20, 1, 1'b0),
      plain_row("6", 1, 1'b0),
      plain_row("5", 2, 1'b0),
      plain_row("3", 1, 1'b0),
      plain_row("5", 1, 1'b0),
      pinned_row(8'h20, KIND_LENGTH, 8'h00, 16'hffff, 1'b0),
      mode_row(1'b1),
      plain_row("6", 1, 1'b0),
      plain_row("5", 2, 1'b0),
      plain_row("3", 1, 1'b0),
      error_row("6", ERR_LENGTH_LARGE),
      plain_row("7", 1, 1'b0),
      error_row("#", ERR_BAD_DIGIT),
      plain_row("2", 1, 1'b0),
      plain_row(8'h0a, 1, 1'b0),
      plain_row(8'h20, 1, 1'b0),
      plain_row(8'hff, 1, 1'b1),
      plain_row(8'h00, 1, 1'b1),
      mode_row(1'b0),
      plain_row("q", 32, 1'b0),
      error_row("q", ERR_CODE_LONG)
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_mode(dir_rows[i].b[0]);
      end else begin
        repeat (dir_rows[i].reps) begin
          send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].pinned, dir_rows[i].want);
        end
      end
    end

    next_cfg_at = items_sent + $urandom_range(150, 350);
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_cfg_at) begin
        // A message left open in its length or body is abandoned by the mode write.
        if ($urandom_range(0, 1) == 1) begin
          send_message(1'b0,
                       ($urandom_range(0, 3) == 0) ? MAX_BODY : int'($urandom_range(1000, MAX_BODY)),
                       $urandom_range(0, 5));
        end
        write_mode(($urandom_range(0, 3) == 0) ? cur_mode : !cur_mode);
        next_cfg_at = items_sent + $urandom_range(150, 350);
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)), rand_last(), 1'b0, '0);
      end else begin
        send_message(pick < 20, -1, MAX_BODY);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_parse_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
